// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the rtl files of the point in tetrahedron block
// expects signals named clk and rst_n in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_NOW(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/pit_pkg.sv =====
// shared types, constants and microcode program of the point in tetrahedron block
// no dependencies
package pit_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int NUM_STEPS = 18;

    typedef logic [4:0] step_t;

    localparam logic [1:0] LAST_FACET = 2'd3;

    // facet vertex order a, b, c
    localparam logic [1:0] FACET_TAB [4][3] = '{
        '{2'd0, 2'd1, 2'd3},
        '{2'd1, 2'd2, 2'd3},
        '{2'd2, 2'd0, 2'd3},
        '{2'd0, 2'd2, 2'd1}
    };

    typedef enum logic [1:0] {RD_NONE, RD_A, RD_B, RD_C} rd_role_t;
    typedef enum logic [1:0] {D_NONE, D_AP, D_AB, D_AC} diff_op_t;
    typedef enum logic [1:0] {MA_AC, MA_LO, MA_HI} mula_sel_t;
    typedef enum logic {MB_AB, MB_AP} mulb_sel_t;
    typedef enum logic [2:0] {OP_NONE, OP_HOLD, OP_CR, ACC_SET, ACC_ADD, ACC_ADD_HI} acc_op_t;
    typedef enum logic {FL_NEXT, FL_CHECK} flow_t;

    typedef enum logic {SQ_IDLE, SQ_RUN} seq_state_t;

    typedef struct packed {
        rd_role_t   rd;
        diff_op_t   dop;
        mula_sel_t  a_sel;
        logic [1:0] a_idx;
        mulb_sel_t  b_sel;
        logic [1:0] b_idx;
        acc_op_t    op;
        logic [1:0] cr_idx;
        flow_t      flow;
    } ctrl_t;

    typedef struct packed {
        logic idle;
        logic running;
        logic finish;
    } seq_stat_t;

    localparam ctrl_t CTRL_NOP = '0;

    function automatic logic [1:0] facet_vertex(logic [1:0] facet, rd_role_t role);
        logic [1:0] v;
        unique case (role)
            RD_B:    v = FACET_TAB[facet][1];
            RD_C:    v = FACET_TAB[facet][2];
            default: v = FACET_TAB[facet][0];
        endcase
        return v;
    endfunction

    function automatic ctrl_t cw(rd_role_t rd, diff_op_t dop, mula_sel_t as, logic [1:0] ai,
                                 mulb_sel_t bs, logic [1:0] bi, acc_op_t op,
                                 logic [1:0] ci, flow_t fl);
        ctrl_t w;
        w.rd     = rd;
        w.dop    = dop;
        w.a_sel  = as;
        w.a_idx  = ai;
        w.b_sel  = bs;
        w.b_idx  = bi;
        w.op     = op;
        w.cr_idx = ci;
        w.flow   = fl;
        return w;
    endfunction

    // one facet: vertex reads and differences, cross product, split dot product, sign check
    function automatic ctrl_t ucode_word(step_t s);
        ctrl_t w;
        unique case (s)
            5'd0:  w = cw(RD_A, D_NONE, MA_AC, 2'd0, MB_AB, 2'd0, OP_NONE, 2'd0, FL_NEXT);
            5'd1:  w = cw(RD_B, D_AP, MA_AC, 2'd0, MB_AB, 2'd0, OP_NONE, 2'd0, FL_NEXT);
            5'd2:  w = cw(RD_C, D_AB, MA_AC, 2'd0, MB_AB, 2'd0, OP_NONE, 2'd0, FL_NEXT);
            5'd3:  w = cw(RD_NONE, D_AC, MA_AC, 2'd0, MB_AB, 2'd0, OP_NONE, 2'd0, FL_NEXT);
            5'd4:  w = cw(RD_NONE, D_NONE, MA_AC, 2'd1, MB_AB, 2'd2, OP_NONE, 2'd0, FL_NEXT);
            5'd5:  w = cw(RD_NONE, D_NONE, MA_AC, 2'd2, MB_AB, 2'd1, OP_HOLD, 2'd0, FL_NEXT);
            5'd6:  w = cw(RD_NONE, D_NONE, MA_AC, 2'd2, MB_AB, 2'd0, OP_CR, 2'd0, FL_NEXT);
            5'd7:  w = cw(RD_NONE, D_NONE, MA_AC, 2'd0, MB_AB, 2'd2, OP_HOLD, 2'd0, FL_NEXT);
            5'd8:  w = cw(RD_NONE, D_NONE, MA_AC, 2'd0, MB_AB, 2'd1, OP_CR, 2'd1, FL_NEXT);
            5'd9:  w = cw(RD_NONE, D_NONE, MA_AC, 2'd1, MB_AB, 2'd0, OP_HOLD, 2'd0, FL_NEXT);
            5'd10: w = cw(RD_NONE, D_NONE, MA_LO, 2'd0, MB_AP, 2'd0, OP_CR, 2'd2, FL_NEXT);
            5'd11: w = cw(RD_NONE, D_NONE, MA_LO, 2'd1, MB_AP, 2'd1, ACC_SET, 2'd0, FL_NEXT);
            5'd12: w = cw(RD_NONE, D_NONE, MA_LO, 2'd2, MB_AP, 2'd2, ACC_ADD, 2'd0, FL_NEXT);
            5'd13: w = cw(RD_NONE, D_NONE, MA_HI, 2'd0, MB_AP, 2'd0, ACC_ADD, 2'd0, FL_NEXT);
            5'd14: w = cw(RD_NONE, D_NONE, MA_HI, 2'd1, MB_AP, 2'd1, ACC_ADD_HI, 2'd0, FL_NEXT);
            5'd15: w = cw(RD_NONE, D_NONE, MA_HI, 2'd2, MB_AP, 2'd2, ACC_ADD_HI, 2'd0, FL_NEXT);
            5'd16: w = cw(RD_NONE, D_NONE, MA_AC, 2'd0, MB_AB, 2'd0, ACC_ADD_HI, 2'd0, FL_NEXT);
            5'd17: w = cw(RD_NONE, D_NONE, MA_AC, 2'd0, MB_AB, 2'd0, OP_NONE, 2'd0, FL_CHECK);
            default: w = CTRL_NOP;
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/pit_seq.sv =====
// microcode sequencer: step counter, facet counter and control word fetch
// depends on pit_pkg and assert_macros.svh
`include "assert_macros.svh"

module pit_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              out_free,
    output pit_pkg::ctrl_t    ctrl,
    output logic [1:0]        facet,
    output pit_pkg::seq_stat_t stat
);
    import pit_pkg::*;

    seq_state_t state_reg, state_next;
    step_t      step_reg, step_next;
    logic [1:0] facet_reg, facet_next;
    ctrl_t      word;
    logic       finish;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SQ_IDLE;
            step_reg  <= '0;
            facet_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            facet_reg <= facet_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        facet_next = facet_reg;
        finish     = 1'b0;
        word       = ucode_word(step_reg);
        unique case (state_reg)
            SQ_IDLE:
            begin
                if (start)
                begin
                    state_next = SQ_RUN;
                    step_next  = '0;
                    facet_next = '0;
                end
            end
            SQ_RUN:
            begin
                if (word.flow == FL_CHECK)
                begin
                    if (facet_reg == LAST_FACET)
                    begin
                        // hold on the check step until the result slot is free
                        if (out_free)
                        begin
                            finish     = 1'b1;
                            state_next = SQ_IDLE;
                        end
                    end
                    else
                    begin
                        facet_next = facet_reg + 2'd1;
                        step_next  = '0;
                    end
                end
                else
                begin
                    step_next = step_reg + 5'd1;
                end
            end
            default: state_next = SQ_IDLE;
        endcase
    end

    assign ctrl         = (state_reg == SQ_RUN) ? word : CTRL_NOP;
    assign facet        = facet_reg;
    assign stat.idle    = (state_reg == SQ_IDLE);
    assign stat.running = (state_reg == SQ_RUN);
    assign stat.finish  = finish;

    `ASSERT_NEXT(a_start_clean, start && state_reg == SQ_IDLE,
        state_reg == SQ_RUN && step_reg == '0 && facet_reg == '0, "bad test start")
    `ASSERT_NEXT(a_finish_idle, finish, state_reg == SQ_IDLE, "no idle after finish")
    `ASSERT_NEXT(a_facet_adv,
        state_reg == SQ_RUN && word.flow == FL_CHECK && facet_reg != LAST_FACET,
        step_reg == '0 && facet_reg == $past(facet_reg) + 2'd1, "facet did not advance")

endmodule

// ===== hw/rtl/point_in_tetrahedron_test.sv =====
// Point in tetrahedron test. A load (func 0) writes one of four vertices.
// A test (func 1) checks the point against the four facets and gives one inside_res,
// 1 when the point lies inside or on the boundary. A test occupies the block after its
// transfer for 18 microcode steps per facet, set by the one shared
// multiplier that does the six cross product and six split dot product products of
// each facet, plus the one-port vertex store reads. A finished result waits in an
// output register while the next item is taken; a test that finishes while that
// register is still full holds on its last step until the waiting result is taken.
// Vertices read as zero after reset.
// depends on pit_pkg, pit_seq and assert_macros.svh
`include "assert_macros.svh"

module point_in_tetrahedron_test #(
    parameter int COORD_WIDTH = pit_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          func,
    input  logic [1:0]                    vertex_index,
    input  logic signed [COORD_WIDTH-1:0] x_coord,
    input  logic signed [COORD_WIDTH-1:0] y_coord,
    input  logic signed [COORD_WIDTH-1:0] z_coord,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          inside_res
);
    import pit_pkg::*;

    localparam int W     = COORD_WIDTH;
    localparam int DW    = W + 1;
    localparam int SPLIT = W + 1;
    localparam int MAW   = W + 2;
    localparam int PW    = 2 * W + 3;
    localparam int AW    = 3 * W + 6;

    ctrl_t      ctrl;
    logic [1:0] facet;
    seq_stat_t  stat;
    logic       in_xfer, start, load_xfer, out_free;

    logic [3*W-1:0]        vtx_mem [4];
    logic [3:0]            vld_reg;
    logic [3*W-1:0]        rd_reg;
    logic [1:0]            rd_addr;
    logic signed [W-1:0]   rd_c [3];
    logic signed [W-1:0]   pt_reg [3];
    logic signed [W-1:0]   a_reg [3];
    logic signed [DW-1:0]  ab_reg [3];
    logic signed [DW-1:0]  ac_reg [3];
    logic signed [DW-1:0]  ap_reg [3];
    logic signed [PW-1:0]  cr_reg [3];
    logic signed [PW-1:0]  hold_reg;
    logic signed [PW-1:0]  prod_reg;
    logic signed [AW-1:0]  acc_reg;
    logic signed [MAW-1:0] mul_a;
    logic signed [DW-1:0]  mul_b;
    logic                  inside_reg, facet_ok;
    logic                  out_valid_reg, inside_res_reg;

    assign in_xfer   = in_valid && in_ready;
    assign start     = in_xfer && func;
    assign load_xfer = in_xfer && !func;
    assign in_ready  = stat.idle;
    assign out_free  = !out_valid_reg || out_ready;

    pit_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .out_free (out_free),
        .ctrl     (ctrl),
        .facet    (facet),
        .stat     (stat)
    );

    // vertex store
    assign rd_addr = facet_vertex(facet, ctrl.rd);

    always_ff @(posedge clk)
    begin
        if (load_xfer)
            vtx_mem[vertex_index] <= {x_coord, y_coord, z_coord};
        if (ctrl.rd != RD_NONE)
            rd_reg <= vld_reg[rd_addr] ? vtx_mem[rd_addr] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (load_xfer)
            vld_reg[vertex_index] <= 1'b1;
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            rd_c[k] = $signed(rd_reg[(2-k)*W +: W]);
    end

    // operand select for the shared multiplier
    always_comb
    begin
        unique case (ctrl.a_sel)
            MA_AC:   mul_a = MAW'(ac_reg[ctrl.a_idx]);
            MA_LO:   mul_a = $signed({1'b0, cr_reg[ctrl.a_idx][SPLIT-1:0]});
            MA_HI:   mul_a = $signed(cr_reg[ctrl.a_idx][PW-1:SPLIT]);
            default: mul_a = '0;
        endcase
        unique case (ctrl.b_sel)
            MB_AB:   mul_b = ab_reg[ctrl.b_idx];
            MB_AP:   mul_b = ap_reg[ctrl.b_idx];
            default: mul_b = '0;
        endcase
    end

    assign facet_ok = inside_reg && !acc_reg[AW-1];

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            pt_reg[0] <= x_coord;
            pt_reg[1] <= y_coord;
            pt_reg[2] <= z_coord;
        end
        for (int k = 0; k < 3; k++)
        begin
            unique case (ctrl.dop)
                D_AP:
                begin
                    ap_reg[k] <= DW'(pt_reg[k]) - DW'(rd_c[k]);
                    a_reg[k]  <= rd_c[k];
                end
                D_AB:    ab_reg[k] <= DW'(rd_c[k]) - DW'(a_reg[k]);
                D_AC:    ac_reg[k] <= DW'(rd_c[k]) - DW'(a_reg[k]);
                default: ;
            endcase
        end
        prod_reg <= mul_a * mul_b;
        unique case (ctrl.op)
            OP_HOLD:    hold_reg <= prod_reg;
            OP_CR:      cr_reg[ctrl.cr_idx] <= hold_reg - prod_reg;
            ACC_SET:    acc_reg <= AW'(prod_reg);
            ACC_ADD:    acc_reg <= acc_reg + AW'(prod_reg);
            ACC_ADD_HI: acc_reg <= acc_reg + (AW'(prod_reg) <<< SPLIT);
            default:    ;
        endcase
        if (stat.finish)
            inside_res_reg <= facet_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg    <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (start)
                inside_reg <= 1'b1;
            else if (ctrl.flow == FL_CHECK)
                inside_reg <= facet_ok;
            if (stat.finish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign inside_res = inside_res_reg;

    `ASSERT_NEXT(a_test_busy, in_valid && in_ready && func, !in_ready, "took item while busy")
    `ASSERT_NOW(a_finish_free, stat.finish |-> (!out_valid_reg || out_ready),
        "result overwritten")
    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(inside_res),
        "waiting result changed")

endmodule

// ===== tb/pit_check.sv =====
// result checker for point_in_tetrahedron_test, with the item code package it shares with tb
// keeps its own vertex store, predicts inside_res for every test transfer and compares
// depends on pit_pkg (coordinate width, facet table)
package pit_tb_pkg;

    typedef enum logic {FN_LOAD = 1'b0, FN_TEST = 1'b1} func_code_t;

endpackage

module pit_check #(
    parameter int CW = pit_pkg::COORD_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic                 func,
    input  logic [1:0]           vertex_index,
    input  logic signed [CW-1:0] x_coord,
    input  logic signed [CW-1:0] y_coord,
    input  logic signed [CW-1:0] z_coord,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic                 inside_res,
    output int                   fail_count,
    output int                   results_pending,
    output int                   load_count,
    output int                   test_count,
    output int                   inside_count
);
    import pit_tb_pkg::*;

    logic signed [CW-1:0] vstore [4][3] = '{default: '0};
    bit inside_expected [$];
    int n_fail = 0;
    int n_load = 0;
    int n_test = 0;
    int n_inside = 0;

    // all four facet volumes must be zero or positive
    function automatic bit point_inside(input longint px, input longint py, input longint pz);
        longint p [3];
        longint a [3];
        longint ab [3];
        longint ac [3];
        longint ap [3];
        longint nrm [3];
        longint vol;
        bit ok;
        ok = 1'b1;
        p[0] = px;
        p[1] = py;
        p[2] = pz;
        for (int f = 0; f < 4; f++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                a[k]  = vstore[pit_pkg::FACET_TAB[f][0]][k];
                ab[k] = vstore[pit_pkg::FACET_TAB[f][1]][k] - a[k];
                ac[k] = vstore[pit_pkg::FACET_TAB[f][2]][k] - a[k];
                ap[k] = p[k] - a[k];
            end
            nrm[0] = ac[1] * ab[2] - ac[2] * ab[1];
            nrm[1] = ac[2] * ab[0] - ac[0] * ab[2];
            nrm[2] = ac[0] * ab[1] - ac[1] * ab[0];
            vol = nrm[0] * ap[0] + nrm[1] * ap[1] + nrm[2] * ap[2];
            if (vol < 0)
                ok = 1'b0;
        end
        return ok;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        bit want;
        if (!rst_n)
        begin
            for (int v = 0; v < 4; v++)
                for (int k = 0; k < 3; k++)
                    vstore[v][k] = '0;
            inside_expected.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (inside_expected.size() == 0)
                begin
                    n_fail++;
                    $display("%0t: result with none expected, expected none, actual inside_res=%0b",
                             $time, inside_res);
                end
                else
                begin
                    want = inside_expected.pop_front();
                    if (inside_res !== want)
                    begin
                        n_fail++;
                        $display("%0t: inside_res mismatch, expected %0b, actual %0b",
                                 $time, want, inside_res);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (func == FN_LOAD)
                begin
                    vstore[vertex_index][0] = x_coord;
                    vstore[vertex_index][1] = y_coord;
                    vstore[vertex_index][2] = z_coord;
                    n_load++;
                end
                else
                begin
                    want = point_inside(x_coord, y_coord, z_coord);
                    inside_expected.push_back(want);
                    n_test++;
                    if (want)
                        n_inside++;
                end
            end
        end
        fail_count      <= n_fail;
        results_pending <= inside_expected.size();
        load_count      <= n_load;
        test_count      <= n_test;
        inside_count    <= n_inside;
    end

endmodule

// ===== tb/tb.sv =====
// top of the point_in_tetrahedron_test bench: clock, reset, vertex load and point test
// stimulus with random idling on both channels, watchdog and verdict
// depends on pit_pkg, pit_tb_pkg, pit_check and the block itself
module tb;
    import pit_tb_pkg::*;

    localparam int CW             = pit_pkg::COORD_WIDTH_DEF;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int PHASE_ITEMS    = 150;

    typedef logic signed [CW-1:0] coord_t;

    localparam coord_t C_LO  = coord_t'(-(2 ** (CW - 1)));
    localparam coord_t C_HI  = coord_t'(2 ** (CW - 1) - 1);
    localparam coord_t C_MID = coord_t'(-16000);

    logic       clk;
    logic       rst_n        = 1'b0;
    logic       in_valid     = 1'b0;
    logic       in_ready;
    logic       func         = 1'b0;
    logic [1:0] vertex_index = 2'd0;
    coord_t     x_coord      = '0;
    coord_t     y_coord      = '0;
    coord_t     z_coord      = '0;
    logic       out_valid;
    logic       out_ready    = 1'b0;
    logic       inside_res;

    int fail_count;
    int results_pending;
    int load_count;
    int test_count;
    int inside_count;

    int tx_idle_pct = 13;
    int rx_idle_pct = 77;
    int sent = 0;
    int idle_cycles = 0;
    coord_t tet [4][3];

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    point_in_tetrahedron_test dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .vertex_index (vertex_index),
        .x_coord      (x_coord),
        .y_coord      (y_coord),
        .z_coord      (z_coord),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .inside_res   (inside_res)
    );

    pit_check #(.CW(CW)) inside_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .vertex_index    (vertex_index),
        .x_coord         (x_coord),
        .y_coord         (y_coord),
        .z_coord         (z_coord),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .inside_res      (inside_res),
        .fail_count      (fail_count),
        .results_pending (results_pending),
        .load_count      (load_count),
        .test_count      (test_count),
        .inside_count    (inside_count)
    );

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= rx_idle_pct);

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_item(input func_code_t f, input logic [1:0] idx,
                             input coord_t x, input coord_t y, input coord_t z);
        int gap;
        if ($urandom_range(99) < tx_idle_pct)
        begin
            gap = ($urandom_range(3) == 0) ? $urandom_range(90, 1) : $urandom_range(4, 1);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        func         <= f;
        vertex_index <= idx;
        x_coord      <= x;
        y_coord      <= y;
        z_coord      <= z;
        do @(posedge clk); while (!in_ready);
        sent++;
    endtask

    task automatic load_vertex(input logic [1:0] idx, input coord_t x, input coord_t y,
                               input coord_t z);
        tet[idx][0] = x;
        tet[idx][1] = y;
        tet[idx][2] = z;
        send_item(FN_LOAD, idx, x, y, z);
    endtask

    // hold the sender off until every test result has come back
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (results_pending != 0);
    endtask

    function automatic coord_t rand_coord(input int span);
        if (span == 0)
            return coord_t'($urandom);
        return coord_t'(int'($urandom_range(2 * span)) - span);
    endfunction

    // weighted mix of the loaded vertices, zero weights put it on faces and edges
    task automatic test_convex();
        longint w [4];
        longint wsum;
        longint acc;
        coord_t p [3];
        wsum = 0;
        for (int v = 0; v < 4; v++)
        begin
            w[v] = ($urandom_range(3) == 0) ? longint'(0) : longint'($urandom_range(255));
            wsum += w[v];
        end
        if (wsum == 0)
        begin
            w[0] = 1;
            wsum = 1;
        end
        for (int k = 0; k < 3; k++)
        begin
            acc = 0;
            for (int v = 0; v < 4; v++)
                acc += w[v] * tet[v][k];
            p[k] = coord_t'(acc / wsum);
        end
        send_item(FN_TEST, 2'($urandom), p[0], p[1], p[2]);
    endtask

    task automatic tetra_sequence();
        int span;
        int sel;
        int ntests;
        logic [1:0] idx;
        case ($urandom_range(3))
            0:       span = 0;
            1:       span = 30000;
            2:       span = 1000;
            default: span = 20;
        endcase
        sel = $urandom_range(1);
        for (int v = 0; v < 4; v++)
        begin
            idx = sel ? 2'(3 - v) : 2'(v);
            load_vertex(idx, rand_coord(span), rand_coord(span), rand_coord(span));
        end
        ntests = $urandom_range(6, 1);
        repeat (ntests)
        begin
            idx = 2'($urandom);
            case ($urandom_range(9))
                0: send_item(FN_TEST, 2'($urandom), tet[idx][0], tet[idx][1], tet[idx][2]);
                1: send_item(FN_TEST, 2'($urandom), rand_coord(0), rand_coord(0),
                             rand_coord(0));
                2: send_item(FN_TEST, 2'($urandom), tet[idx][0] + coord_t'(rand_coord(2)),
                             tet[idx][1] + coord_t'(rand_coord(2)),
                             tet[idx][2] + coord_t'(rand_coord(2)));
                default: test_convex();
            endcase
        end
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct);
        int target;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        target = sent + PHASE_ITEMS;
        while (sent < target)
        begin
            if ($urandom_range(99) < 80)
                tetra_sequence();
            else if ($urandom_range(1) == 0)
                load_vertex(2'($urandom), rand_coord(0), rand_coord(0), rand_coord(0));
            else
                send_item(FN_TEST, 2'($urandom), rand_coord(0), rand_coord(0), rand_coord(0));
            if ($urandom_range(99) < 3)
                drain();
        end
        drain();
    endtask

    initial
    begin
        for (int v = 0; v < 4; v++)
            for (int k = 0; k < 3; k++)
                tet[v][k] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty store is flat, so everything tests inside
        send_item(FN_TEST, 2'd0, '0, '0, '0);
        send_item(FN_TEST, 2'd3, C_HI, C_LO, C_HI);

        // full range corner tetrahedron, outward facets
        load_vertex(2'd0, C_LO, C_LO, C_LO);
        load_vertex(2'd1, C_HI, C_LO, C_LO);
        load_vertex(2'd2, C_LO, C_HI, C_LO);
        load_vertex(2'd3, C_LO, C_LO, C_HI);
        send_item(FN_TEST, 2'd1, C_MID, C_MID, C_MID);
        send_item(FN_TEST, 2'd2, C_HI, C_LO, C_LO);
        send_item(FN_TEST, 2'd0, '0, '0, C_LO);
        send_item(FN_TEST, 2'd3, C_HI, C_HI, C_HI);
        send_item(FN_TEST, 2'd0, C_LO, C_LO, C_LO);

        // swapped vertices turn the facets inward
        load_vertex(2'd1, C_LO, C_HI, C_LO);
        load_vertex(2'd2, C_HI, C_LO, C_LO);
        send_item(FN_TEST, 2'd1, C_MID, C_MID, C_MID);

        // all four vertices in one plane
        load_vertex(2'd3, '0, '0, C_LO);
        send_item(FN_TEST, 2'd2, C_HI, C_HI, C_HI);
        drain();

        run_phase(13, 77);
        run_phase(77, 13);
        run_phase(0, 0);

        in_valid <= 1'b0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d vertex loads and %0d point tests (%0d inside, %0d outside)",
                 load_count, test_count, inside_count, test_count - inside_count);
        $display("under sender-heavy, receiver-heavy and no idling, %0d check failures",
                 fail_count);
        if (fail_count == 0 && results_pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
